// ===== sv/severity_priority_queue_top_macros.svh =====
// assertion macros for the severity priority queue checker
// no dependencies; expects clk_i and rst_ni in the scope of use
`ifndef SEVERITY_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SEVERITY_PRIORITY_QUEUE_TOP_MACROS_SVH

// property that must hold at every edge out of reset
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sevpq_pkg.sv =====
// types, sizes and codes shared by the severity priority queue
// no dependencies
`timescale 1ns / 1ps
package sevpq_pkg;

  localparam int QueueDepth = 64;
  localparam int IdBits     = 16;
  localparam int SevBits    = 8;
  localparam int CountBits  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    FuncAdmit = 2'd0,
    FuncServe = 2'd1,
    FuncClear = 2'd2
  } sevpq_func_e;

  typedef enum logic [2:0] {
    StatAdmitted = 3'd0,
    StatServed   = 3'd1,
    StatEmpty    = 3'd2,
    StatFull     = 3'd3,
    StatCleared  = 3'd4
  } sevpq_status_e;

  typedef struct packed {
    logic [IdBits-1:0]  id;
    logic [SevBits-1:0] sev;
  } sevpq_entry_t;

  typedef struct packed {
    logic         insert;
    logic         remove;
    sevpq_entry_t entry;
  } sevpq_cmd_t;

endpackage

// ===== sv/sevpq_cell.sv =====
// one position of the sorted store: holds an entry, shifts on insert or remove
// depends on sevpq_pkg
`timescale 1ns / 1ps
module sevpq_cell import sevpq_pkg::*; (
  input  logic         clk_i,
  input  sevpq_cmd_t   cmd_i,
  input  logic         occupied_i,
  input  logic         prev_keep_i,
  input  sevpq_entry_t prev_entry_i,
  input  sevpq_entry_t next_entry_i,
  output logic         keep_o,
  output sevpq_entry_t entry_o
);

  sevpq_entry_t entry_q, entry_d;

  // stays put when it outranks or ties the new entry
  assign keep_o  = occupied_i && (entry_q.sev >= cmd_i.entry.sev);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.insert && !keep_o) begin
      entry_d = prev_keep_i ? cmd_i.entry : prev_entry_i;
    end else if (cmd_i.remove) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== sv/severity_priority_queue_top.sv =====
// severity priority queue: decode, occupancy count and a chain of sorted cells
// depends on sevpq_pkg and sevpq_cell
//
// channel  | handshake        | payload
// ---------+------------------+-------------------------------------
// command  | start, busy      | func_i, entry_id_i, severity_i
// result   | done_o (strobe)  | status_o, served_id_o, occupancy_o
//
// one command per cycle; its result shows in the cycle after the transfer
// every cell compares and shifts in parallel, so busy stays low
// reset clears the count and result registers, not the cells; cell contents are read only below the count
// the result is a one-cycle strobe and cannot be held off
`timescale 1ns / 1ps
module severity_priority_queue_top import sevpq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           func_i,
  input  logic [IdBits-1:0]    entry_id_i,
  input  logic [SevBits-1:0]   severity_i,
  output logic                 done_o,
  output logic [2:0]           status_o,
  output logic [IdBits-1:0]    served_id_o,
  output logic [CountBits-1:0] occupancy_o
);

  logic                 accept;
  logic                 is_full, is_empty;
  sevpq_cmd_t           cmd;
  logic                 keep    [QueueDepth];
  sevpq_entry_t         entries [QueueDepth];

  logic [CountBits-1:0] count_q, count_d;
  logic                 done_q;
  sevpq_status_e        status_q, status_d;
  logic [IdBits-1:0]    served_q, served_d;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count_q == CountBits'(QueueDepth));
  assign is_empty = (count_q == '0);

  always_comb begin
    cmd.insert    = 1'b0;
    cmd.remove    = 1'b0;
    cmd.entry.id  = entry_id_i;
    cmd.entry.sev = severity_i;
    count_d       = count_q;
    status_d      = status_q;
    served_d      = '0;
    if (accept) begin
      unique case (func_i) inside
        FuncAdmit: begin
          if (is_full) begin
            status_d = StatFull;
          end else begin
            cmd.insert = 1'b1;
            count_d    = count_q + CountBits'(1);
            status_d   = StatAdmitted;
          end
        end
        FuncServe: begin
          if (is_empty) begin
            status_d = StatEmpty;
          end else begin
            cmd.remove = 1'b1;
            count_d    = count_q - CountBits'(1);
            served_d   = entries[0].id;
            status_d   = StatServed;
          end
        end
        default: begin
          count_d  = '0;
          status_d = StatCleared;
        end
      endcase
    end
  end

  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    logic         prev_keep;
    sevpq_entry_t prev_entry, next_entry;

    if (g == 0) begin : g_head
      assign prev_keep  = 1'b1;
      assign prev_entry = entries[g];
    end else begin : g_body
      assign prev_keep  = keep[g-1];
      assign prev_entry = entries[g-1];
    end

    if (g == QueueDepth - 1) begin : g_tail
      assign next_entry = entries[g];
    end else begin : g_inner
      assign next_entry = entries[g+1];
    end

    sevpq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occupied_i  (count_q > CountBits'(g)),
      .prev_keep_i (prev_keep),
      .prev_entry_i(prev_entry),
      .next_entry_i(next_entry),
      .keep_o      (keep[g]),
      .entry_o     (entries[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= StatAdmitted;
      served_q <= '0;
    end else begin
      count_q  <= count_d;
      done_q   <= accept;
      status_q <= status_d;
      served_q <= served_d;
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign served_id_o = served_q;
  assign occupancy_o = count_q;

endmodule

// ===== sv/sevpq_checker.sv =====
// port-level checks for the severity priority queue, bound to the top level
// depends on sevpq_pkg and severity_priority_queue_top_macros.svh
`timescale 1ns / 1ps
`include "severity_priority_queue_top_macros.svh"
module sevpq_checker import sevpq_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 done_o,
  input logic [2:0]           status_o,
  input logic [IdBits-1:0]    served_id_o,
  input logic [CountBits-1:0] occupancy_o
);

  `SPQ_ASSERT_NEXT(a_result_follows, start && !busy, done_o, "transfer gave no result")
  `SPQ_ASSERT_NEXT(a_no_spurious, !(start && !busy), !done_o, "result without a transfer")
  `SPQ_ASSERT(a_served_id_zero, !done_o || status_o == StatServed || served_id_o == '0,
    "served id not zero")
  `SPQ_ASSERT(a_clear_empties, !done_o || status_o != StatCleared || occupancy_o == '0,
    "clear left entries")
  `SPQ_ASSERT(a_occ_bound, occupancy_o <= CountBits'(QueueDepth), "occupancy past depth")

endmodule

bind severity_priority_queue_top sevpq_checker u_sevpq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .status_o   (status_o),
  .served_id_o(served_id_o),
  .occupancy_o(occupancy_o)
);

// ===== dv/tb_severity_priority_queue_top.sv =====
// self-checking testbench for the severity priority queue top level
// depends on sevpq_pkg and severity_priority_queue_top; own sorted-queue predictor
`timescale 1ns / 1ps
module tb_severity_priority_queue_top;
  import sevpq_pkg::*;

  localparam logic [1:0] FuncSpare  = 2'd3;
  localparam int         RandomCmds = 1300;

  typedef struct {
    logic [1:0]         func;
    logic [IdBits-1:0]  id;
    logic [SevBits-1:0] sev;
  } spq_cmd_t;

  typedef struct {
    sevpq_status_e        status;
    logic [IdBits-1:0]    served_id;
    logic [CountBits-1:0] occupancy;
  } spq_result_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           func_i = FuncAdmit;
  logic [IdBits-1:0]    entry_id_i = '0;
  logic [SevBits-1:0]   severity_i = '0;
  logic                 done_o;
  logic [2:0]           status_o;
  logic [IdBits-1:0]    served_id_o;
  logic [CountBits-1:0] occupancy_o;

  spq_cmd_t     pending_cmds[$];
  spq_result_t  expected_results[$];
  sevpq_entry_t waiting_entries[$];

  logic xfer_seen = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   total_cmds = 0;
  int   accepted_cmds = 0;
  int   checked_results = 0;
  int   mismatches = 0;
  int   gen_count = 0;
  int   n_admitted = 0;
  int   n_served = 0;
  int   n_empty = 0;
  int   n_full = 0;
  int   n_cleared = 0;

  severity_priority_queue_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .func_i      (func_i),
    .entry_id_i  (entry_id_i),
    .severity_i  (severity_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .served_id_o (served_id_o),
    .occupancy_o (occupancy_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // queue a command and track the occupancy the generator expects
  task automatic queue_cmd(input logic [1:0] func, input logic [IdBits-1:0] id,
                           input logic [SevBits-1:0] sev);
    spq_cmd_t c;
    c.func = func;
    c.id   = id;
    c.sev  = sev;
    pending_cmds.push_back(c);
    total_cmds++;
    if (func[1]) begin
      gen_count = 0;
    end else if (func == FuncServe) begin
      if (gen_count > 0) gen_count--;
    end else if (gen_count < QueueDepth) begin
      gen_count++;
    end
  endtask

  function automatic logic [IdBits-1:0] rand_id();
    return IdBits'($urandom_range(0, (1 << IdBits) - 1));
  endfunction

  function automatic logic [SevBits-1:0] rand_sev(input bit narrow);
    if (narrow) return SevBits'($urandom_range(0, 3) * 85);
    return SevBits'($urandom_range(0, (1 << SevBits) - 1));
  endfunction

  task automatic predict_queue(input logic [1:0] func, input logic [IdBits-1:0] id,
                               input logic [SevBits-1:0] sev);
    spq_result_t  r;
    sevpq_entry_t e;
    int           pos;
    r.served_id = '0;
    if (func[1]) begin
      waiting_entries.delete();
      r.status = StatCleared;
      n_cleared++;
    end else if (func == FuncServe) begin
      if (waiting_entries.size() == 0) begin
        r.status = StatEmpty;
        n_empty++;
      end else begin
        e = waiting_entries.pop_front();
        r.served_id = e.id;
        r.status = StatServed;
        n_served++;
      end
    end else if (waiting_entries.size() >= QueueDepth) begin
      r.status = StatFull;
      n_full++;
    end else begin
      // stable insert: behind every entry of equal or higher severity
      pos = 0;
      while (pos < waiting_entries.size() && waiting_entries[pos].sev >= sev) pos++;
      e.id  = id;
      e.sev = sev;
      waiting_entries.insert(pos, e);
      r.status = StatAdmitted;
      n_admitted++;
    end
    r.occupancy = CountBits'(waiting_entries.size());
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input spq_result_t exp_r);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected status %0d id %h occ %0d, got status %0d id %h occ %0d",
               $realtime, what, exp_r.status, exp_r.served_id, exp_r.occupancy,
               status_o, served_id_o, occupancy_o);
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    spq_cmd_t c;
    if (rst_ni) begin
      if (!start || xfer_seen) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          func_i     <= c.func;
          entry_id_i <= c.id;
          severity_i <= c.sev;
          start      <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    spq_result_t exp_r;
    if (!rst_ni) begin
      xfer_seen <= 1'b0;
    end else begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          exp_r.status    = StatAdmitted;
          exp_r.served_id = '0;
          exp_r.occupancy = '0;
          report_mismatch("result with nothing outstanding", exp_r);
        end else begin
          exp_r = expected_results.pop_front();
          checked_results++;
          if (status_o !== exp_r.status || served_id_o !== exp_r.served_id ||
              occupancy_o !== exp_r.occupancy) begin
            report_mismatch("result mismatch", exp_r);
          end
        end
      end
      xfer_seen <= start && !busy;
      if (start && !busy) begin
        predict_queue(func_i, entry_id_i, severity_i);
        accepted_cmds++;
      end
    end
  end

  initial begin
    #2ms;
    $display("timeout: %0d of %0d commands accepted, %0d results outstanding",
             accepted_cmds, total_cmds, expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int  kind;
    int  len;
    int  pct;
    int  pick;
    int  n_random;
    bit  narrow;

    // directed: empty serve, field extremes, ties, drain past empty, both clear codes
    queue_cmd(FuncServe, rand_id(), rand_sev(1'b0));
    queue_cmd(FuncAdmit, 16'h0000, 8'h00);
    queue_cmd(FuncAdmit, 16'hffff, 8'hff);
    queue_cmd(FuncAdmit, 16'h1234, 8'hff);
    queue_cmd(FuncAdmit, 16'h8000, 8'h00);
    queue_cmd(FuncAdmit, 16'h00ff, 8'h80);
    queue_cmd(FuncAdmit, 16'h5a5a, 8'h7f);
    repeat (6) queue_cmd(FuncServe, rand_id(), rand_sev(1'b0));
    queue_cmd(FuncServe, rand_id(), rand_sev(1'b0));
    queue_cmd(FuncAdmit, 16'haaaa, 8'h55);
    queue_cmd(FuncAdmit, 16'h5555, 8'haa);
    queue_cmd(FuncSpare, rand_id(), rand_sev(1'b0));
    queue_cmd(FuncServe, rand_id(), rand_sev(1'b0));
    queue_cmd(FuncAdmit, 16'h0001, 8'h01);
    queue_cmd(FuncClear, rand_id(), rand_sev(1'b0));
    queue_cmd(FuncClear, rand_id(), rand_sev(1'b0));
    queue_cmd(FuncServe, rand_id(), rand_sev(1'b0));

    // random: mixed traffic, fills past full, drains past empty
    n_random = 0;
    while (n_random < RandomCmds) begin
      kind   = $urandom_range(0, 99);
      narrow = $urandom_range(0, 1);
      if (kind < 70) begin
        len = $urandom_range(10, 50);
        pct = $urandom_range(25, 75);
        repeat (len) begin
          pick = $urandom_range(0, 99);
          if (pick < 2) begin
            queue_cmd($urandom_range(0, 1) ? FuncClear : FuncSpare, rand_id(), rand_sev(1'b0));
          end else if (pick < pct) begin
            queue_cmd(FuncAdmit, rand_id(), rand_sev(narrow));
          end else begin
            queue_cmd(FuncServe, rand_id(), rand_sev(1'b0));
          end
        end
        n_random += len;
      end else if (kind < 85) begin
        len = $urandom_range(1, 4);
        while (gen_count < QueueDepth) begin
          queue_cmd(FuncAdmit, rand_id(), rand_sev(narrow));
          n_random++;
        end
        repeat (len) queue_cmd(FuncAdmit, rand_id(), rand_sev(narrow));
        n_random += len;
      end else begin
        len = $urandom_range(1, 3);
        while (gen_count > 0) begin
          queue_cmd(FuncServe, rand_id(), rand_sev(1'b0));
          n_random++;
        end
        repeat (len) queue_cmd(FuncServe, rand_id(), rand_sev(1'b0));
        n_random += len;
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (accepted_cmds != total_cmds || expected_results.size() != 0);
    repeat (5) @(negedge clk_i);

    $display("%0d commands, %0d results checked: %0d admitted, %0d served, %0d empty serves,",
             total_cmds, checked_results, n_admitted, n_served, n_empty);
    $display("%0d dropped on full, %0d clears; %0d mismatches", n_full, n_cleared, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== severity_priority_queue_top.f =====
+incdir+sv
sv/sevpq_pkg.sv
sv/sevpq_cell.sv
sv/severity_priority_queue_top.sv
sv/sevpq_checker.sv
dv/tb_severity_priority_queue_top.sv
